>>> src/solar_incidence_fraction_assert.svh
// Assertion macros shared by the RTL.
`ifndef SOLAR_INCIDENCE_FRACTION_ASSERT_SVH
`define SOLAR_INCIDENCE_FRACTION_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SIF_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define SIF_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sif_pkg.sv
package sif_pkg;

    localparam int DAY_BITS       = 9;
    localparam int TRIG_FRAC_BITS = 16;

    localparam int CORDIC_STEPS     = 26;
    localparam int CORDIC_FRAC      = 30;
    localparam int CORDIC_GAIN_INIT = 652032874;
    localparam int CORDIC_LATENCY   = CORDIC_STEPS + 2;
    localparam int ATAN_W           = 30;

    localparam logic [ATAN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd170876734, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20
    };

    localparam int HALF_SCALE = 32768;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LATITUDE  = 3'd0,
        CFG_LONGITUDE = 3'd1,
        CFG_TILT      = 3'd2,
        CFG_HPD       = 3'd3,
        CFG_SID_RATE  = 3'd4,
        CFG_YEAR_RATE = 3'd5,
        CFG_SHADE     = 3'd6
    } cfg_idx_t;

    localparam logic [15:0] LATITUDE_RST  = 16'd0;
    localparam logic [15:0] LONGITUDE_RST = 16'd0;
    localparam logic [14:0] TILT_RST      = 15'd4267;
    localparam logic [5:0]  HPD_RST       = 6'd24;
    localparam logic [31:0] SID_RATE_RST  = 32'd179446937;
    localparam logic [31:0] YEAR_RATE_RST = 32'd490293;
    localparam logic        SHADE_RST     = 1'b1;

    typedef struct packed {
        logic [DAY_BITS-1:0] day_of_year;
        logic [5:0]          hour_of_day;
    } sample_t;

    typedef struct packed {
        logic [15:0] solar_fraction;
        logic [15:0] shade_factor;
    } result_t;

endpackage

>>> src/sif_cordic.sv
module sif_cordic #(
    parameter int TRIG_FRAC_BITS = sif_pkg::TRIG_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [15:0]                      angle,
    output logic signed [TRIG_FRAC_BITS+2:0] sin_val,
    output logic signed [TRIG_FRAC_BITS+2:0] cos_val
);

    localparam int STEPS = sif_pkg::CORDIC_STEPS;
    localparam int XW    = sif_pkg::CORDIC_FRAC + 3;
    localparam int ZW    = 34;
    localparam int OW    = TRIG_FRAC_BITS + 3;
    localparam int SH    = sif_pkg::CORDIC_FRAC - TRIG_FRAC_BITS;

    logic signed [XW-1:0] x_reg [STEPS+1];
    logic signed [XW-1:0] y_reg [STEPS+1];
    logic signed [ZW-1:0] z_reg [STEPS+1];
    logic                 flip_reg [STEPS+1];

    logic signed [XW-1:0] x_next [STEPS];
    logic signed [XW-1:0] y_next [STEPS];
    logic signed [ZW-1:0] z_next [STEPS];

    logic [31:0]          ang32;
    logic [31:0]          quad;
    logic                 flip;
    logic [31:0]          folded;
    logic signed [XW-1:0] x_rnd;
    logic signed [XW-1:0] y_rnd;
    logic signed [OW-1:0] x_out;
    logic signed [OW-1:0] y_out;

    // fold into [-1/4, 1/4) turn
    always_comb
    begin
        ang32  = {angle, 16'h0000};
        quad   = ang32 + 32'h4000_0000;
        flip   = quad[31];
        folded = flip ? (ang32 + 32'h8000_0000) : ang32;
    end

    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed({{(ZW-sif_pkg::ATAN_W){1'b0}},
                                                sif_pkg::ATAN_TURNS[i]});
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed({{(ZW-sif_pkg::ATAN_W){1'b0}},
                                                sif_pkg::ATAN_TURNS[i]});
            end
        end
    end

    always_comb
    begin
        x_rnd = (x_reg[STEPS] + (XW'(1) <<< (SH - 1))) >>> SH;
        y_rnd = (y_reg[STEPS] + (XW'(1) <<< (SH - 1))) >>> SH;
        x_out = OW'(x_rnd);
        y_out = OW'(y_rnd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= XW'(sif_pkg::CORDIC_GAIN_INIT);
            y_reg[0]    <= '0;
            z_reg[0]    <= ZW'($signed(folded));
            flip_reg[0] <= flip;
            for (int i = 0; i < STEPS; i++)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_val <= flip_reg[STEPS] ? -x_out : x_out;
            sin_val <= flip_reg[STEPS] ? -y_out : y_out;
        end
    end

endmodule

>>> src/solar_incidence_fraction.sv
// Channel   Direction  Payload                          Handshake
// sample    in         sif_pkg::sample_t (day, hour)    sample_valid / sample_ready
// result    out        sif_pkg::result_t (frac, shade)  result_valid / result_ready
// cfg       in         cfg_index, cfg_data              cfg_valid / cfg_ready
//
// One transaction per cycle sustained while sample_ready is high.
// The CORDIC pipeline (one micro-rotation per stage) sets the depth.
// The whole datapath advances together; a two-entry result buffer lets inputs
// keep flowing while one result waits. sample_ready drops only when it is full.
// Reset clears valid bits, buffer pointers and config registers to defaults.
`include "solar_incidence_fraction_assert.svh"

module solar_incidence_fraction #(
    parameter int DAY_BITS       = sif_pkg::DAY_BITS,
    parameter int TRIG_FRAC_BITS = sif_pkg::TRIG_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  sif_pkg::sample_t                  sample,
    output logic                              result_valid,
    input  logic                              result_ready,
    output sif_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sif_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int W       = TRIG_FRAC_BITS + 3;
    localparam int PW      = 2 * W;
    localparam int SUMW    = PW + 1;
    localparam int HOURS_W = DAY_BITS + 7;
    localparam int NV      = 3 + sif_pkg::CORDIC_LATENCY + 12 + 1;

    typedef logic signed [W-1:0]    val_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [SUMW-1:0] sum_t;

    typedef struct packed {
        val_t ax;
        val_t az;
        val_t ls;
        val_t lc;
        val_t ss;
        val_t sc;
        val_t ys;
        val_t yc;
    } side_t;

    localparam val_t ONE_Q   = val_t'(64'sd1 <<< TRIG_FRAC_BITS);
    localparam sum_t FRAC_MAX = sum_t'(sif_pkg::HALF_SCALE);

    function automatic val_t qround(input prod_t p);
        prod_t t;
        t = (p + (prod_t'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        return val_t'(t);
    endfunction

    // configuration
    logic [15:0] lat_reg;
    logic [15:0] lon_reg;
    logic [14:0] tilt_reg;
    logic [5:0]  hpd_reg;
    logic [31:0] sid_rate_reg;
    logic [31:0] yr_rate_reg;
    logic        shade_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg      <= sif_pkg::LATITUDE_RST;
            lon_reg      <= sif_pkg::LONGITUDE_RST;
            tilt_reg     <= sif_pkg::TILT_RST;
            hpd_reg      <= sif_pkg::HPD_RST;
            sid_rate_reg <= sif_pkg::SID_RATE_RST;
            yr_rate_reg  <= sif_pkg::YEAR_RATE_RST;
            shade_reg    <= sif_pkg::SHADE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sif_pkg::CFG_LATITUDE:  lat_reg      <= cfg_data[15:0];
                sif_pkg::CFG_LONGITUDE: lon_reg      <= cfg_data[15:0];
                sif_pkg::CFG_TILT:      tilt_reg     <= cfg_data[14:0];
                sif_pkg::CFG_HPD:       hpd_reg      <= cfg_data[5:0];
                sif_pkg::CFG_SID_RATE:  sid_rate_reg <= cfg_data;
                sif_pkg::CFG_YEAR_RATE: yr_rate_reg  <= cfg_data;
                sif_pkg::CFG_SHADE:     shade_reg    <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // pipeline control
    logic          adv;
    logic [NV-1:0] vld_reg;
    logic [1:0]    cnt_reg;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic          push;
    logic          pop;

    assign adv          = (cnt_reg != 2'd2);
    assign sample_ready = adv;
    assign push         = adv && vld_reg[NV-1];
    assign pop          = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NV-2:0], sample_valid};
        end
    end

    // input, hours, angles
    logic [DAY_BITS-1:0] day_reg;
    logic [5:0]          hour_reg;
    logic [HOURS_W-1:0]  hours_reg;
    logic [31:0]         sid_prod;
    logic [31:0]         yr_prod;
    logic [15:0]         lt_ang_reg;
    logic [15:0]         tilt_ang_reg;
    logic [15:0]         lon_ang_reg;
    logic [15:0]         sid_ang_reg;
    logic [15:0]         yr_ang_reg;

    assign sid_prod = 32'(hours_reg) * sid_rate_reg;
    assign yr_prod  = 32'(hours_reg) * yr_rate_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            day_reg      <= DAY_BITS'(sample.day_of_year);
            hour_reg     <= sample.hour_of_day;
            hours_reg    <= HOURS_W'(day_reg * hpd_reg) + HOURS_W'(hour_reg);
            lt_ang_reg   <= lat_reg + {1'b0, tilt_reg};
            tilt_ang_reg <= {1'b0, tilt_reg};
            lon_ang_reg  <= lon_reg;
            sid_ang_reg  <= sid_prod[31:16];
            yr_ang_reg   <= yr_prod[31:16];
        end
    end

    // trig
    val_t lt_s, lt_c, ti_s, ti_c, lo_s, lo_c, si_s, si_c, yr_s, yr_c;

    sif_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_lt (
        .clk(clk), .en(adv), .angle(lt_ang_reg), .sin_val(lt_s), .cos_val(lt_c));
    sif_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_tilt (
        .clk(clk), .en(adv), .angle(tilt_ang_reg), .sin_val(ti_s), .cos_val(ti_c));
    sif_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_lon (
        .clk(clk), .en(adv), .angle(lon_ang_reg), .sin_val(lo_s), .cos_val(lo_c));
    sif_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_sid (
        .clk(clk), .en(adv), .angle(sid_ang_reg), .sin_val(si_s), .cos_val(si_c));
    sif_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic_yr (
        .clk(clk), .en(adv), .angle(yr_ang_reg), .sin_val(yr_s), .cos_val(yr_c));

    // two Rodrigues rotations, six stages each
    val_t  vin       [2][3];
    side_t side_in   [2];
    val_t  rs4       [2];
    val_t  kk4       [2];

    val_t  v1_reg    [2][3];
    prod_t pa1_reg   [2][4];
    side_t side1_reg [2];
    val_t  v2_reg    [2][3];
    val_t  w2_reg    [2][3];
    side_t side2_reg [2];
    val_t  v3_reg    [2][3];
    val_t  w3_reg    [2][3];
    prod_t pb3_reg   [2][4];
    side_t side3_reg [2];
    val_t  v4_reg    [2][3];
    val_t  w4_reg    [2][3];
    val_t  u4_reg    [2][3];
    side_t side4_reg [2];
    val_t  v5_reg    [2][3];
    prod_t ps5_reg   [2][3];
    prod_t pk5_reg   [2][3];
    side_t side5_reg [2];
    val_t  v6_reg    [2][3];
    side_t side6_reg [2];

    always_comb
    begin
        vin[0][0]       = lt_c;
        vin[0][1]       = '0;
        vin[0][2]       = lt_s;
        side_in[0].ax   = -ti_s;
        side_in[0].az   = ti_c;
        side_in[0].ls   = lo_s;
        side_in[0].lc   = lo_c;
        side_in[0].ss   = si_s;
        side_in[0].sc   = si_c;
        side_in[0].ys   = yr_s;
        side_in[0].yc   = yr_c;
        for (int j = 0; j < 3; j++)
        begin
            vin[1][j] = v6_reg[0][j];
        end
        side_in[1] = side6_reg[0];
        rs4[0] = side4_reg[0].ls;
        kk4[0] = ONE_Q - side4_reg[0].lc;
        rs4[1] = side4_reg[1].ss;
        kk4[1] = ONE_Q - side4_reg[1].sc;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 2; r++)
            begin
                side1_reg[r] <= side_in[r];
                side2_reg[r] <= side1_reg[r];
                side3_reg[r] <= side2_reg[r];
                side4_reg[r] <= side3_reg[r];
                side5_reg[r] <= side4_reg[r];
                side6_reg[r] <= side5_reg[r];

                pa1_reg[r][0] <= $signed(side_in[r].az) * vin[r][1];
                pa1_reg[r][1] <= $signed(side_in[r].az) * vin[r][0];
                pa1_reg[r][2] <= $signed(side_in[r].ax) * vin[r][2];
                pa1_reg[r][3] <= $signed(side_in[r].ax) * vin[r][1];

                w2_reg[r][0] <= -qround(pa1_reg[r][0]);
                w2_reg[r][1] <= qround(pa1_reg[r][1]) - qround(pa1_reg[r][2]);
                w2_reg[r][2] <= qround(pa1_reg[r][3]);

                pb3_reg[r][0] <= $signed(side2_reg[r].az) * w2_reg[r][1];
                pb3_reg[r][1] <= $signed(side2_reg[r].az) * w2_reg[r][0];
                pb3_reg[r][2] <= $signed(side2_reg[r].ax) * w2_reg[r][2];
                pb3_reg[r][3] <= $signed(side2_reg[r].ax) * w2_reg[r][1];

                u4_reg[r][0] <= -qround(pb3_reg[r][0]);
                u4_reg[r][1] <= qround(pb3_reg[r][1]) - qround(pb3_reg[r][2]);
                u4_reg[r][2] <= qround(pb3_reg[r][3]);

                for (int j = 0; j < 3; j++)
                begin
                    v1_reg[r][j]  <= vin[r][j];
                    v2_reg[r][j]  <= v1_reg[r][j];
                    v3_reg[r][j]  <= v2_reg[r][j];
                    w3_reg[r][j]  <= w2_reg[r][j];
                    v4_reg[r][j]  <= v3_reg[r][j];
                    w4_reg[r][j]  <= w3_reg[r][j];
                    v5_reg[r][j]  <= v4_reg[r][j];
                    ps5_reg[r][j] <= rs4[r] * w4_reg[r][j];
                    pk5_reg[r][j] <= kk4[r] * u4_reg[r][j];
                    v6_reg[r][j]  <= v5_reg[r][j] + qround(ps5_reg[r][j])
                                     + qround(pk5_reg[r][j]);
                end
            end
        end
    end

    // dot with sun vector
    prod_t dp0_reg;
    prod_t dp1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp0_reg <= $signed(side6_reg[1].yc) * v6_reg[1][0];
            dp1_reg <= $signed(side6_reg[1].ys) * v6_reg[1][1];
        end
    end

    sum_t             dot_sum;
    sum_t             frac;
    logic [15:0]      frac16;
    sif_pkg::result_t res_new;

    always_comb
    begin
        dot_sum = sum_t'(dp0_reg) + sum_t'(dp1_reg);
        frac    = (dot_sum + (sum_t'(1) <<< (2 * TRIG_FRAC_BITS - 16)))
                  >>> (2 * TRIG_FRAC_BITS - 15);
        if (frac[SUMW-1])
        begin
            frac16 = '0;
        end
        else if (frac > FRAC_MAX)
        begin
            frac16 = 16'(sif_pkg::HALF_SCALE);
        end
        else
        begin
            frac16 = frac[15:0];
        end
        res_new.solar_fraction = frac16;
        res_new.shade_factor   = shade_reg ? frac16 : 16'(sif_pkg::HALF_SCALE);
    end

    // result buffer
    sif_pkg::result_t ent_reg [2];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = ent_reg[rd_ptr_reg];

    `SIF_ASSERT_NOW(a_stall_full, !sample_ready, cnt_reg == 2'd2, "stall without full buffer")
    `SIF_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "count up")
    `SIF_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1, "count down")
    `SIF_ASSERT_NOW(a_frac_max, result_valid, result.solar_fraction <= 16'd32768, "fraction")

endmodule
